/* rtl/core/rfpc_pkg.sv */
// shared types and constants for the radio front panel controller
package rfpc_pkg;

    localparam int FreqW    = 16;
    localparam int VolW     = 6;
    localparam int StepW    = 8;
    localparam int TimerW   = 8;
    localparam int MaskW    = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // register indexes on the config port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_FREQUENCY  = 3'd0,
        CFG_START_VOLUME     = 3'd1,
        CFG_VOLUME_STEP      = 3'd2,
        CFG_VOLUME_LIMIT     = 3'd3,
        CFG_TUNE_STEP        = 3'd4,
        CFG_CLICK_WINDOW     = 3'd5,
        CFG_ANIMATION_PERIOD = 3'd6
    } rfpc_cfg_idx_t;

    // register defaults after reset
    localparam logic [FreqW-1:0]  DefStartFrequency = 16'd10140;
    localparam logic [VolW-1:0]   DefStartVolume    = 6'd30;
    localparam logic [VolW-1:0]   DefVolumeStep     = 6'd15;
    localparam logic [VolW-1:0]   DefVolumeLimit    = 6'd60;
    localparam logic [StepW-1:0]  DefTuneStep       = 8'd10;
    localparam logic [TimerW-1:0] DefClickWindow    = 8'd25;
    localparam logic [TimerW-1:0] DefAnimPeriod     = 8'd12;

    localparam logic [VolW-1:0]   VolMax            = 6'd63;

    // click detector phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HELD = 2'd1,
        PH_WAIT = 2'd2,
        PH_SEEK = 2'd3
    } rfpc_phase_t;

    // per-beat control from the top level to the state holders
    typedef struct packed {
        logic step;     // a beat moves into the result register this cycle
        logic restart;  // that beat is a restart request
    } rfpc_step_t;

endpackage

/* rtl/core/rfpc_volume.sv */
// volume level with press edge detection, wrap and clamp
module rfpc_volume (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rfpc_pkg::rfpc_step_t       ctl,
    input  logic                       pressed,
    input  logic [rfpc_pkg::VolW-1:0]  start_volume,
    input  logic [rfpc_pkg::VolW-1:0]  volume_step,
    input  logic [rfpc_pkg::VolW-1:0]  volume_limit,
    output logic                       write,
    output logic [rfpc_pkg::VolW-1:0]  level_next
);
    import rfpc_pkg::*;

    logic [VolW-1:0] level_reg;
    logic            was_pressed_reg;
    logic            was_pressed_next;
    logic [VolW:0]   sum;

    assign sum = {1'b0, level_reg} + {1'b0, volume_step};

    always_comb
    begin
        write            = 1'b0;
        level_next       = level_reg;
        was_pressed_next = was_pressed_reg;
        if (ctl.restart)
        begin
            write            = 1'b1;
            level_next       = start_volume;
            was_pressed_next = 1'b0;
        end
        else if (pressed)
        begin
            if (!was_pressed_reg)
            begin
                write            = 1'b1;
                was_pressed_next = 1'b1;
                priority if (sum > {1'b0, volume_limit})
                    level_next = '0;
                else if (sum > {1'b0, VolMax})
                    level_next = VolMax;
                else
                    level_next = sum[VolW-1:0];
            end
        end
        else
        begin
            was_pressed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= DefStartVolume;
            was_pressed_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            level_reg       <= level_next;
            was_pressed_reg <= was_pressed_next;
        end
    end

endmodule

/* rtl/core/rfpc_click.sv */
// single / double click detector for one tune button
module rfpc_click (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rfpc_pkg::rfpc_step_t         ctl,
    input  logic                         pressed,
    input  logic [rfpc_pkg::TimerW-1:0]  click_window,
    output logic                         single_click,
    output logic                         seek
);
    import rfpc_pkg::*;

    rfpc_phase_t       phase_reg, phase_next;
    logic [TimerW-1:0] timer_reg, timer_next;
    logic              timed_out;

    assign timed_out = (timer_reg >= click_window);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                    phase_next = PH_HELD;
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
            end
            PH_WAIT:
            begin
                priority if (pressed)
                    phase_next = PH_SEEK;
                else if (timed_out)
                    phase_next = PH_IDLE;
                else
                    timer_next = timer_reg + 1'b1;
            end
            PH_SEEK:
            begin
                if (!pressed)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        single_click = 1'b0;
        seek         = 1'b0;
        if (!ctl.restart && phase_reg == PH_WAIT)
        begin
            seek         = pressed;
            single_click = !pressed && timed_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.restart)
            begin
                phase_reg <= PH_IDLE;
                timer_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
            end
        end
    end

endmodule

/* rtl/core/rfpc_led.sv */
// bouncing led bar count with thermometer mask output
module rfpc_led #(
    parameter int LED_COUNT = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rfpc_pkg::rfpc_step_t         ctl,
    input  logic [rfpc_pkg::TimerW-1:0]  animation_period,
    output logic                         write,
    output logic [rfpc_pkg::MaskW-1:0]   mask
);
    import rfpc_pkg::*;

    localparam int LitW = $clog2(LED_COUNT + 1);
    localparam logic [LitW:0] LitTop = (LitW + 1)'(LED_COUNT);

    logic [LitW-1:0]   lit_reg, lit_next;
    logic              rising_reg, rising_next;
    logic [TimerW-1:0] timer_reg, timer_next;
    logic [TimerW:0]   tick_sum;
    logic [LitW:0]     lit_moved;

    assign tick_sum = {1'b0, timer_reg} + 1'b1;

    always_comb
    begin
        write       = 1'b0;
        mask        = '0;
        lit_next    = lit_reg;
        rising_next = rising_reg;
        timer_next  = tick_sum[TimerW-1:0];
        lit_moved   = {1'b0, lit_reg};
        if (!ctl.restart && tick_sum >= {1'b0, animation_period})
        begin
            write      = 1'b1;
            timer_next = '0;
            for (int i = 0; i < MaskW; i++)
                mask[i] = (int'(lit_reg) > i);
            if (rising_reg)
                lit_moved = {1'b0, lit_reg} + 1'b1;
            else if (lit_reg != '0)
                lit_moved = {1'b0, lit_reg} - 1'b1;
            if (lit_moved >= LitTop)
            begin
                lit_moved   = LitTop;
                rising_next = 1'b0;
            end
            if (lit_moved == '0)
                rising_next = 1'b1;
            lit_next = lit_moved[LitW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg    <= '0;
            rising_reg <= 1'b1;
            timer_reg  <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.restart)
            begin
                lit_reg    <= '0;
                rising_reg <= 1'b1;
                timer_reg  <= '0;
            end
            else
            begin
                lit_reg    <= lit_next;
                rising_reg <= rising_next;
                timer_reg  <= timer_next;
            end
        end
    end

endmodule

/* rtl/core/radio_front_panel_controller.sv */
// radio front panel controller top level: config, tick pipeline, frequency
//
// usage
//   one input beat per 10 ms tick: restart plus three button levels
//   (volume, tune down, tune up). every input beat gives exactly one
//   result beat with volume / frequency write flags and values, seek
//   start pulses for double clicks and an led bar mask with its write flag.
//   config registers are written by the user via cfg_write / cfg_index /
//   cfg_data while no beat is in flight (not enforced); index 7 is ignored.
// timing
//   a beat lands in the input register, the state update runs as short
//   logic from there into the result register, which raises out_valid.
//   one beat per cycle sustained while out_ready stays high, set by the
//   single input-register to result-register stage.
// reset and stall
//   reset loads register defaults and the start volume / frequency,
//   clears all detectors and empties both stages. a stalled receiver
//   holds the result register; one more beat waits in the input register
//   and in_ready drops only when both are full.
module radio_front_panel_controller #(
    parameter int LED_COUNT = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_write,
    input  logic [rfpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [rfpc_pkg::CfgDataW-1:0]  cfg_data,
    // tick beats in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           restart,
    input  logic                           volume_pressed,
    input  logic                           down_pressed,
    input  logic                           up_pressed,
    // result beats out
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           volume_write,
    output logic [rfpc_pkg::VolW-1:0]      volume_value,
    output logic                           tune_write,
    output logic [rfpc_pkg::FreqW-1:0]     frequency_value,
    output logic                           seek_down_start,
    output logic                           seek_up_start,
    output logic                           led_write,
    output logic [rfpc_pkg::MaskW-1:0]     led_mask
);
    import rfpc_pkg::*;

    // config registers
    logic [FreqW-1:0]  start_frequency_reg;
    logic [VolW-1:0]   start_volume_reg;
    logic [VolW-1:0]   volume_step_reg;
    logic [VolW-1:0]   volume_limit_reg;
    logic [StepW-1:0]  tune_step_reg;
    logic [TimerW-1:0] click_window_reg;
    logic [TimerW-1:0] anim_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_frequency_reg <= DefStartFrequency;
            start_volume_reg    <= DefStartVolume;
            volume_step_reg     <= DefVolumeStep;
            volume_limit_reg    <= DefVolumeLimit;
            tune_step_reg       <= DefTuneStep;
            click_window_reg    <= DefClickWindow;
            anim_period_reg     <= DefAnimPeriod;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_FREQUENCY:  start_frequency_reg <= cfg_data[FreqW-1:0];
                CFG_START_VOLUME:     start_volume_reg    <= cfg_data[VolW-1:0];
                CFG_VOLUME_STEP:      volume_step_reg     <= cfg_data[VolW-1:0];
                CFG_VOLUME_LIMIT:     volume_limit_reg    <= cfg_data[VolW-1:0];
                CFG_TUNE_STEP:        tune_step_reg       <= cfg_data[StepW-1:0];
                CFG_CLICK_WINDOW:     click_window_reg    <= cfg_data[TimerW-1:0];
                CFG_ANIMATION_PERIOD: anim_period_reg     <= cfg_data[TimerW-1:0];
                default:              ; // unused index, write dropped
            endcase
        end
    end

    // input register
    logic s1_valid_reg;
    logic s1_restart_reg;
    logic s1_vol_reg;
    logic s1_down_reg;
    logic s1_up_reg;
    logic advance;
    logic in_accept;

    // a beat moves on when the result register is empty or being drained
    assign advance   = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_restart_reg <= restart;
            s1_vol_reg     <= volume_pressed;
            s1_down_reg    <= down_pressed;
            s1_up_reg      <= up_pressed;
        end
    end

    rfpc_step_t ctl;
    assign ctl.step    = advance;
    assign ctl.restart = s1_restart_reg;

    // volume
    logic            vol_wr;
    logic [VolW-1:0] vol_next;

    rfpc_volume u_volume (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .pressed      (s1_vol_reg),
        .start_volume (start_volume_reg),
        .volume_step  (volume_step_reg),
        .volume_limit (volume_limit_reg),
        .write        (vol_wr),
        .level_next   (vol_next)
    );

    // tune buttons
    logic dn_click, dn_seek;
    logic up_click, up_seek;

    rfpc_click u_click_down (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .pressed      (s1_down_reg),
        .click_window (click_window_reg),
        .single_click (dn_click),
        .seek         (dn_seek)
    );

    rfpc_click u_click_up (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .pressed      (s1_up_reg),
        .click_window (click_window_reg),
        .single_click (up_click),
        .seek         (up_seek)
    );

    // frequency: single clicks step it with saturation, both together cancel
    logic [FreqW-1:0] freq_reg, freq_next;
    logic             tune_wr;
    logic [FreqW:0]   freq_up;

    assign freq_up = {1'b0, freq_reg} + {{(FreqW + 1 - StepW){1'b0}}, tune_step_reg};

    always_comb
    begin
        freq_next = freq_reg;
        tune_wr   = 1'b0;
        if (ctl.restart)
        begin
            freq_next = start_frequency_reg;
            tune_wr   = 1'b1;
        end
        else if (dn_click || up_click)
        begin
            tune_wr = 1'b1;
            if (dn_click && !up_click)
            begin
                if (freq_reg < {{(FreqW - StepW){1'b0}}, tune_step_reg})
                    freq_next = '0;
                else
                    freq_next = freq_reg - {{(FreqW - StepW){1'b0}}, tune_step_reg};
            end
            else if (up_click && !dn_click)
            begin
                if (freq_up[FreqW])
                    freq_next = '1;
                else
                    freq_next = freq_up[FreqW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            freq_reg <= DefStartFrequency;
        else if (advance)
            freq_reg <= freq_next;
    end

    // led bar
    logic             led_wr;
    logic [MaskW-1:0] led_mask_next;

    rfpc_led #(
        .LED_COUNT (LED_COUNT)
    ) u_led (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .animation_period (anim_period_reg),
        .write            (led_wr),
        .mask             (led_mask_next)
    );

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            volume_write    <= vol_wr;
            volume_value    <= vol_next;
            tune_write      <= tune_wr;
            frequency_value <= freq_next;
            seek_down_start <= dn_seek;
            seek_up_start   <= up_seek;
            led_write       <= led_wr;
            led_mask        <= led_mask_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the radio front panel controller
module testbench;
    import rfpc_pkg::*;

    localparam int LedCount    = 8;
    localparam int CycleLimit  = 300000;
    localparam int RandomTicks = 1100;
    localparam int SettleTicks = 6;

    // button generator slots
    localparam int BtnVolume = 0;
    localparam int BtnDown   = 1;
    localparam int BtnUp     = 2;

    // one tick as it goes into the block
    typedef struct packed {
        logic restart;
        logic volume;
        logic down;
        logic up;
    } panel_tick_t;

    // one result beat as the block should report it
    typedef struct packed {
        logic             volume_write;
        logic [VolW-1:0]  volume_value;
        logic             tune_write;
        logic [FreqW-1:0] frequency_value;
        logic             seek_down;
        logic             seek_up;
        logic             led_write;
        logic [MaskW-1:0] led_mask;
    } panel_report_t;

    // clock, reset and block ports; every input is known from time zero
    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                cfg_write       = 1'b0;
    rfpc_cfg_idx_t       cfg_index       = CFG_START_FREQUENCY;
    logic [CfgDataW-1:0] cfg_data        = '0;
    logic                in_valid        = 1'b0;
    logic                in_ready;
    logic                restart         = 1'b0;
    logic                volume_pressed  = 1'b0;
    logic                down_pressed    = 1'b0;
    logic                up_pressed      = 1'b0;
    logic                out_valid;
    logic                out_ready       = 1'b0;
    logic                volume_write;
    logic [VolW-1:0]     volume_value;
    logic                tune_write;
    logic [FreqW-1:0]    frequency_value;
    logic                seek_down_start;
    logic                seek_up_start;
    logic                led_write;
    logic [MaskW-1:0]    led_mask;

    radio_front_panel_controller #(
        .LED_COUNT(LedCount)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .volume_pressed (volume_pressed),
        .down_pressed   (down_pressed),
        .up_pressed     (up_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .volume_write   (volume_write),
        .volume_value   (volume_value),
        .tune_write     (tune_write),
        .frequency_value(frequency_value),
        .seek_down_start(seek_down_start),
        .seek_up_start  (seek_up_start),
        .led_write      (led_write),
        .led_mask       (led_mask)
    );

    always #2 clk = ~clk;

    // shadow copy of the config registers, reset defaults
    logic [FreqW-1:0]  reg_start_freq   = DefStartFrequency;
    logic [VolW-1:0]   reg_start_vol    = DefStartVolume;
    logic [VolW-1:0]   reg_vol_step     = DefVolumeStep;
    logic [VolW-1:0]   reg_vol_limit    = DefVolumeLimit;
    logic [StepW-1:0]  reg_tune_step    = DefTuneStep;
    logic [TimerW-1:0] reg_click_window = DefClickWindow;
    logic [TimerW-1:0] reg_anim_period  = DefAnimPeriod;

    // predicted panel state
    int                vol_level;
    int                freq_level;
    logic              vol_held;
    rfpc_phase_t       dn_phase;
    logic [TimerW-1:0] dn_timer;
    rfpc_phase_t       up_phase;
    logic [TimerW-1:0] up_timer;
    int                lit_count;
    logic              lit_rising;
    logic [TimerW-1:0] anim_timer;

    // results predicted for accepted ticks, oldest first
    panel_report_t pending_reports[$];
    panel_report_t expected_report;

    int fail_count  = 0;
    int cycle_count = 0;

    // sender burst state
    int   burst_left    = 0;
    logic steady_sender = 1'b0;

    // receiver stall pattern state
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    // per-button level generators for the random part
    logic btn_level[3] = '{1'b0, 1'b0, 1'b0};
    int   btn_left[3]  = '{0, 0, 0};

    // restart and hardware reset both bring the panel back to the start values
    function automatic void load_start_state();
        vol_level  = int'(reg_start_vol);
        freq_level = int'(reg_start_freq);
        vol_held   = 1'b0;
        dn_phase   = PH_IDLE;
        dn_timer   = '0;
        up_phase   = PH_IDLE;
        up_timer   = '0;
        lit_count  = 0;
        lit_rising = 1'b1;
        anim_timer = '0;
    endfunction

    // one click detector step; returns 1 when a lone click times out
    function automatic logic advance_clicker(inout rfpc_phase_t phase,
                                             inout logic [TimerW-1:0] timer,
                                             input logic pressed,
                                             output logic seek);
        logic lone;
        lone = 1'b0;
        seek = 1'b0;
        case (phase)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase = PH_HELD;
                end
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    phase = PH_WAIT;
                    timer = '0;
                end
            end
            PH_WAIT:
            begin
                // a second press inside the window is a double click
                if (pressed)
                begin
                    seek  = 1'b1;
                    phase = PH_SEEK;
                end
                else if (timer >= reg_click_window)
                begin
                    phase = PH_IDLE;
                    lone  = 1'b1;
                end
                else
                begin
                    timer = timer + 1'b1;
                end
            end
            default:
            begin
                if (!pressed)
                begin
                    phase = PH_IDLE;
                end
            end
        endcase
        return lone;
    endfunction

    // advances the predicted panel by one tick and gives the result it reports
    function automatic panel_report_t panel_response(input panel_tick_t tick);
        panel_report_t rep;
        int            vol_sum;
        int            freq;
        int            next_timer;
        int            lit_shown;
        logic          dn_lone;
        logic          up_lone;
        logic          seek_dn;
        logic          seek_up;
        rep = '0;
        if (tick.restart)
        begin
            // button levels are ignored, both values are reported
            load_start_state();
            rep.volume_write = 1'b1;
            rep.tune_write   = 1'b1;
        end
        else
        begin
            // volume steps on the press edge only
            if (tick.volume)
            begin
                if (!vol_held)
                begin
                    vol_sum  = vol_level + int'(reg_vol_step);
                    vol_held = 1'b1;
                    if (vol_sum > int'(reg_vol_limit))
                    begin
                        vol_sum = 0;
                    end
                    if (vol_sum > 63)
                    begin
                        vol_sum = 63;
                    end
                    vol_level        = vol_sum;
                    rep.volume_write = 1'b1;
                end
            end
            else
            begin
                vol_held = 1'b0;
            end

            dn_lone       = advance_clicker(dn_phase, dn_timer, tick.down, seek_dn);
            up_lone       = advance_clicker(up_phase, up_timer, tick.up, seek_up);
            rep.seek_down = seek_dn;
            rep.seek_up   = seek_up;

            // lone clicks in the same tick give one net change
            if (dn_lone || up_lone)
            begin
                freq = freq_level;
                if (dn_lone)
                begin
                    freq = freq - int'(reg_tune_step);
                end
                if (up_lone)
                begin
                    freq = freq + int'(reg_tune_step);
                end
                if (freq < 0)
                begin
                    freq = 0;
                end
                if (freq > 65535)
                begin
                    freq = 65535;
                end
                freq_level     = freq;
                rep.tune_write = 1'b1;
            end

            // led bar bounces between empty and full
            next_timer = int'(anim_timer) + 1;
            if (next_timer >= int'(reg_anim_period))
            begin
                lit_shown     = (lit_count > LedCount) ? LedCount : lit_count;
                anim_timer    = '0;
                rep.led_mask  = MaskW'((1 << lit_shown) - 1);
                rep.led_write = 1'b1;
                if (lit_rising)
                begin
                    lit_count = lit_count + 1;
                end
                else if (lit_count > 0)
                begin
                    lit_count = lit_count - 1;
                end
                if (lit_count >= LedCount)
                begin
                    lit_count  = LedCount;
                    lit_rising = 1'b0;
                end
                if (lit_count == 0)
                begin
                    lit_rising = 1'b1;
                end
            end
            else
            begin
                anim_timer = next_timer[TimerW-1:0];
            end
        end
        rep.volume_value    = (vol_level > 63) ? VolMax : VolW'(vol_level);
        rep.frequency_value = FreqW'(freq_level);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // holds one beat until accepted, then records what it should produce;
    // called at a rising edge
    task automatic send_tick(input panel_tick_t tick);
        in_valid       <= 1'b1;
        restart        <= tick.restart;
        volume_pressed <= tick.volume;
        down_pressed   <= tick.down;
        up_pressed     <= tick.up;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_reports.push_back(panel_response(tick));
    endtask

    // sender side: bursts of beats, random gaps between them unless steady
    task automatic feed_tick(input logic rs, input logic vol, input logic dn,
                             input logic up);
        panel_tick_t tick;
        tick = '{restart: rs, volume: vol, down: dn, up: up};
        if (burst_left == 0)
        begin
            if (!steady_sender)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        send_tick(tick);
        burst_left--;
    endtask

    // block is idle once every predicted result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleTicks) @(posedge clk);
    endtask

    // one register write; only while idle
    task automatic write_register(input rfpc_cfg_idx_t idx,
                                  input logic [CfgDataW-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_START_FREQUENCY:  reg_start_freq   = value[FreqW-1:0];
            CFG_START_VOLUME:     reg_start_vol    = value[VolW-1:0];
            CFG_VOLUME_STEP:      reg_vol_step     = value[VolW-1:0];
            CFG_VOLUME_LIMIT:     reg_vol_limit    = value[VolW-1:0];
            CFG_TUNE_STEP:        reg_tune_step    = value[StepW-1:0];
            CFG_CLICK_WINDOW:     reg_click_window = value[TimerW-1:0];
            CFG_ANIMATION_PERIOD: reg_anim_period  = value[TimerW-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random settings and button patterns
    // ------------------------------------------------------------------

    // extremes often, anything in range otherwise
    function automatic int pick_field(input int low, input int top);
        case ($urandom_range(0, 4))
            0:       return low;
            1:       return top;
            default: return $urandom_range(low, top);
        endcase
    endfunction

    task automatic pick_random_settings();
        int freq;
        int pick;
        if ($urandom_range(0, 1))
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0:       freq = 0;
                1:       freq = 65535;
                2:       freq = $urandom_range(0, 300);
                3:       freq = 65535 - $urandom_range(0, 300);
                default: freq = $urandom_range(0, 65535);
            endcase
            write_register(CFG_START_FREQUENCY, CfgDataW'(freq));
        end
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_START_VOLUME, CfgDataW'(pick_field(0, 63)));
        end
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_VOLUME_STEP, CfgDataW'(pick_field(0, 63)));
        end
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_VOLUME_LIMIT, CfgDataW'(pick_field(0, 63)));
        end
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_TUNE_STEP, CfgDataW'(pick_field(0, 255)));
        end
        if ($urandom_range(0, 1))
        begin
            // short windows keep click decisions frequent
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                write_register(CFG_CLICK_WINDOW, CfgDataW'(255));
            end
            else if (pick == 1)
            begin
                write_register(CFG_CLICK_WINDOW, CfgDataW'($urandom_range(7, 40)));
            end
            else
            begin
                write_register(CFG_CLICK_WINDOW, CfgDataW'($urandom_range(0, 6)));
            end
        end
        if ($urandom_range(0, 1))
        begin
            // short periods let the bar bounce within one phase
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                write_register(CFG_ANIMATION_PERIOD, CfgDataW'(255));
            end
            else if (pick == 1)
            begin
                write_register(CFG_ANIMATION_PERIOD, CfgDataW'($urandom_range(0, 255)));
            end
            else
            begin
                write_register(CFG_ANIMATION_PERIOD, CfgDataW'($urandom_range(0, 4)));
            end
        end
    endtask

    // press / release runs; tune releases are either inside the click
    // window (double click) or just past it (lone click)
    function automatic logic button_level(input int slot);
        int win;
        win = int'(reg_click_window);
        if (btn_left[slot] == 0)
        begin
            btn_level[slot] = !btn_level[slot];
            if (btn_level[slot] || slot == BtnVolume)
            begin
                btn_left[slot] = $urandom_range(1, 4);
            end
            else if ($urandom_range(0, 1))
            begin
                btn_left[slot] = $urandom_range(1, win + 1);
            end
            else
            begin
                btn_left[slot] = $urandom_range(win + 2, win + 4);
            end
        end
        btn_left[slot]--;
        return btn_level[slot];
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // press edges, holds, wrap past the limit, limit at both ends
    task automatic test_volume_button();
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_START_VOLUME, CfgDataW'(0));
        write_register(CFG_VOLUME_STEP, CfgDataW'(63));
        write_register(CFG_VOLUME_LIMIT, CfgDataW'(63));
        // restart while the button is held; the sum reaches the top exactly
        feed_tick(1'b1, 1'b1, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_VOLUME_STEP, CfgDataW'(0));
        write_register(CFG_VOLUME_LIMIT, CfgDataW'(0));
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b1, 1'b0, 1'b0);
    endtask

    // lone clicks with saturation at both ends, lone clicks together,
    // double clicks on both buttons, zero window and zero led period
    task automatic test_click_detectors();
        wait_idle();
        write_register(CFG_START_FREQUENCY, CfgDataW'(65535));
        write_register(CFG_TUNE_STEP, CfgDataW'(255));
        write_register(CFG_CLICK_WINDOW, CfgDataW'(0));
        write_register(CFG_ANIMATION_PERIOD, CfgDataW'(0));
        feed_tick(1'b1, 1'b1, 1'b1, 1'b1);
        // up click at the top of the range
        feed_tick(1'b0, 1'b0, 1'b0, 1'b1);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        // both lone clicks decided in one tick
        feed_tick(1'b0, 1'b0, 1'b1, 1'b1);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        // double click on both buttons
        feed_tick(1'b0, 1'b0, 1'b1, 1'b1);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b1, 1'b1);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_START_FREQUENCY, CfgDataW'(0));
        // down click at the bottom of the range
        feed_tick(1'b1, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b1, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
        feed_tick(1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // phases of random settings, each opened by a restart; most phases run
    // click patterns, some plain noise, restarts now and then
    task automatic test_random_operation();
        int   ticks_left;
        int   phase_len;
        logic noisy;
        logic rs;
        ticks_left = RandomTicks;
        while (ticks_left > 0)
        begin
            wait_idle();
            pick_random_settings();
            steady_sender = ($urandom_range(0, 3) == 0);
            noisy         = ($urandom_range(0, 6) == 0);
            phase_len     = $urandom_range(40, 140);
            // the last phase stops at the tick budget
            if (phase_len > ticks_left - 1)
            begin
                phase_len = ticks_left - 1;
            end
            feed_tick(1'b1, 1'($urandom), 1'($urandom), 1'($urandom));
            ticks_left--;
            repeat (phase_len)
            begin
                rs = ($urandom_range(0, 49) == 0);
                if (noisy)
                begin
                    feed_tick(rs, 1'($urandom), 1'($urandom), 1'($urandom));
                end
                else
                begin
                    feed_tick(rs, button_level(BtnVolume), button_level(BtnDown),
                              button_level(BtnUp));
                end
                ticks_left--;
            end
        end
        steady_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        load_start_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_volume_button();
        test_click_detectors();
        test_random_operation();

        // drain, then give the pipeline time to show any stray beat
        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver stalls on its own changing pattern, including stretches of
    // always ready
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom);
            2:       out_ready <= (stall_phase % 4 == 0);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic compare_field(input string name, input logic [FreqW-1:0] want,
                                 input logic [FreqW-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // each accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no tick waiting for one");
                fail_count++;
            end
            else
            begin
                expected_report = pending_reports.pop_front();
                compare_field("volume_write", FreqW'(expected_report.volume_write),
                              FreqW'(volume_write));
                compare_field("volume_value", FreqW'(expected_report.volume_value),
                              FreqW'(volume_value));
                compare_field("tune_write", FreqW'(expected_report.tune_write),
                              FreqW'(tune_write));
                compare_field("frequency_value", expected_report.frequency_value,
                              frequency_value);
                compare_field("seek_down_start", FreqW'(expected_report.seek_down),
                              FreqW'(seek_down_start));
                compare_field("seek_up_start", FreqW'(expected_report.seek_up),
                              FreqW'(seek_up_start));
                compare_field("led_write", FreqW'(expected_report.led_write),
                              FreqW'(led_write));
                compare_field("led_mask", FreqW'(expected_report.led_mask),
                              FreqW'(led_mask));
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
